FILE: hdl/kmpi_pkg.sv
// ----------------------------------------------------------------------------
// kmpi_pkg: keyboard and mouse port interface package
// Shared command codes, port addresses, scan codes and ring request type.
// ----------------------------------------------------------------------------
package kmpi_pkg;

  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_READ  = 3'd1,
    CMD_POLL  = 3'd2,
    CMD_KEY   = 3'd3,
    CMD_MOUSE = 3'd4
  } cmd_t;

  localparam logic [7:0] PORT_DATA    = 8'h60;
  localparam logic [7:0] PORT_CTRL    = 8'h61;
  localparam logic [7:0] PORT_PORTC   = 8'h62;
  localparam logic [7:0] PORT_STAT1   = 8'h64;
  localparam logic [7:0] PORT_STAT2   = 8'h65;
  localparam logic [7:0] PORT_SYSRST  = 8'h66;
  localparam logic [7:0] PORT_MOUSE_X = 8'h78;
  localparam logic [7:0] PORT_MOUSE_Y = 8'h7A;

  localparam logic [7:0] CODE_SELFTEST = 8'hAA;
  localparam logic [7:0] CODE_LEFT_DN  = 8'h7E;
  localparam logic [7:0] CODE_LEFT_UP  = 8'hFE;
  localparam logic [7:0] CODE_RIGHT_DN = 8'h7D;
  localparam logic [7:0] CODE_RIGHT_UP = 8'hFD;

  localparam logic [7:0] STAT_SET_MASK  = 8'h0D;
  localparam logic [7:0] STAT_KEEP_MASK = 8'h7F;
  localparam logic [7:0] NIBBLE_MASK    = 8'h0F;
  localparam logic [7:0] RDATA_IDLE     = 8'hFF;

  typedef struct packed {
    logic       push_a;
    logic       push_b;
    logic [7:0] code_a;
    logic [7:0] code_b;
    logic       fetch;
  } ring_req_t;

endpackage

FILE: hdl/keyboard_mouse_port_interface_top.sv
// ----------------------------------------------------------------------------
// keyboard_mouse_port_interface_top: keyboard and mouse port block
// Port decode, control/status bytes, mouse counters and result register.
// ----------------------------------------------------------------------------
// Result word: the input register loads at accept, and the result register loads from it
//   when advance is high (result register empty, or its word taken by out_tready).
// Throughput: one word per cycle unless out_tready stalls; set by the input-to-result pass.
// Reset: synchronous rst_n clears pointers, control/status bytes, counters and
//   handshake state; the ring storage is not cleared and needs no clearing pass.
module keyboard_mouse_port_interface_top #(
  parameter int RING_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // port[7:0] wdata[15:8] mouse_dx[23:16] mouse_dy[31:24]
                                 // mouse_buttons[33:32] speaker_out[34] nmi_pending[35]
  input  logic [2:0]  in_tuser,  // cmd[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata  // rdata[7:0] kbd_irq[8] system_reset[9]
                                 // timer_gate[10] speaker_drive[11]
);
  import kmpi_pkg::*;

  cmd_t       cmd_r;
  logic [7:0] port_r, wdata_r, dx_r, dy_r;
  logic [1:0] btn_in_r;
  logic       spk_r, nmi_r;
  logic       in_valid_r;
  logic       advance;

  logic [7:0] ctrl_r, ctrl_nxt, latch_r, latch_nxt, stat1_r, stat1_nxt;
  logic [7:0] stat2_r, stat2_nxt, cx_r, cx_nxt, cy_r, cy_nxt;
  logic [1:0] btn_r, btn_nxt;
  logic       pend_r, pend_nxt;

  logic       out_valid_r;
  logic [15:0] out_data_r;

  logic [7:0] rdata_c, latch_v, nib, code_l, code_rt;
  logic       irq_c, sysrst_c, fetch_c, left_edge, right_edge;
  ring_req_t  req;
  logic       ring_empty;
  logic [7:0] fetched_code;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r    <= cmd_t'(in_tuser);
      port_r   <= in_tdata[7:0];
      wdata_r  <= in_tdata[15:8];
      dx_r     <= in_tdata[23:16];
      dy_r     <= in_tdata[31:24];
      btn_in_r <= in_tdata[33:32];
      spk_r    <= in_tdata[34];
      nmi_r    <= in_tdata[35];
    end
  end

  always_comb begin
    ctrl_nxt   = ctrl_r;
    latch_nxt  = latch_r;
    stat1_nxt  = stat1_r;
    stat2_nxt  = stat2_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    btn_nxt    = btn_r;
    pend_nxt   = pend_r;
    rdata_c    = RDATA_IDLE;
    irq_c      = 1'b0;
    sysrst_c   = 1'b0;
    fetch_c    = 1'b0;
    req        = '0;
    latch_v    = pend_r ? fetched_code : latch_r;
    nib        = ctrl_r[2] ? (stat2_r & NIBBLE_MASK) : {4'b0000, stat2_r[7:4]};
    left_edge  = btn_in_r[0] ^ btn_r[0];
    right_edge = btn_in_r[1] ^ btn_r[1];
    code_l     = btn_in_r[0] ? CODE_LEFT_DN : CODE_LEFT_UP;
    code_rt    = btn_in_r[1] ? CODE_RIGHT_DN : CODE_RIGHT_UP;
    case (cmd_r)
      CMD_WRITE: begin
        case (port_r)
          PORT_CTRL: begin
            req.push_a = !ctrl_r[6] && wdata_r[6];
            req.code_a = CODE_SELFTEST;
            ctrl_nxt   = wdata_r;
            if (wdata_r[7]) begin
              latch_nxt = '0;
            end
          end
          PORT_STAT1:  stat1_nxt = wdata_r;
          PORT_STAT2:  stat2_nxt = wdata_r;
          PORT_SYSRST: sysrst_c  = 1'b1;
          default: ;
        endcase
      end
      CMD_READ: begin
        case (port_r)
          PORT_DATA: begin
            if (ctrl_r[7]) begin
              rdata_c = (STAT_SET_MASK | stat1_r) & STAT_KEEP_MASK;
            end else begin
              rdata_c  = latch_r;
              fetch_c  = !ring_empty;
              pend_nxt = !ring_empty;
            end
          end
          PORT_CTRL:    rdata_c = ctrl_r;
          PORT_PORTC:   rdata_c = nib | {1'b0, nmi_r, spk_r, 5'b00000};
          PORT_MOUSE_X: begin
            rdata_c = cx_r;
            cx_nxt  = '0;
          end
          PORT_MOUSE_Y: begin
            rdata_c = cy_r;
            cy_nxt  = '0;
          end
          default: ;
        endcase
      end
      CMD_POLL: begin
        irq_c     = pend_r;
        latch_nxt = latch_v;
        pend_nxt  = 1'b0;
        if (!ring_empty && latch_v == '0) begin
          fetch_c  = 1'b1;
          pend_nxt = 1'b1;
        end
      end
      CMD_KEY: begin
        req.push_a = 1'b1;
        req.code_a = wdata_r;
      end
      CMD_MOUSE: begin
        cx_nxt     = cx_r + dx_r;
        cy_nxt     = cy_r - dy_r;
        req.push_a = left_edge || right_edge;
        req.code_a = left_edge ? code_l : code_rt;
        req.push_b = left_edge && right_edge;
        req.code_b = code_rt;
        btn_nxt    = btn_in_r;
      end
      default: ;
    endcase
    req.fetch  = fetch_c && advance;
    req.push_a = req.push_a && advance;
    req.push_b = req.push_b && advance;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r  <= '0;
      latch_r <= '0;
      stat1_r <= '0;
      stat2_r <= '0;
      cx_r    <= '0;
      cy_r    <= '0;
      btn_r   <= '0;
      pend_r  <= 1'b0;
    end else if (advance) begin
      ctrl_r  <= ctrl_nxt;
      latch_r <= latch_nxt;
      stat1_r <= stat1_nxt;
      stat2_r <= stat2_nxt;
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      btn_r   <= btn_nxt;
      pend_r  <= pend_nxt;
    end
  end

  kmpi_ring #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ring (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .empty       (ring_empty),
    .fetched_code(fetched_code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {4'b0000, ctrl_nxt[1], ctrl_nxt[0], sysrst_c, irq_c, rdata_c};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  a_irq_sysrst_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[8] && out_data_r[9]))
    else $error("interrupt and system reset in one result");

  a_gate_tracks_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_data_r[10] == ctrl_r[0] && out_data_r[11] == ctrl_r[1]))
    else $error("timer gate or speaker drive out of step with control byte");
`endif

endmodule

FILE: hdl/kmpi_ring.sv
// ----------------------------------------------------------------------------
// kmpi_ring: scan-code ring
// Two interleaved banks take up to two pushes per word; one fetch per word
// reads the head entry into a registered read port.
// ----------------------------------------------------------------------------
module kmpi_ring #(
  parameter int RING_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kmpi_pkg::ring_req_t req,
  output logic                empty,
  output logic [7:0]          fetched_code
);
  import kmpi_pkg::*;

  localparam int PhysDepth = 2 * ((RING_DEPTH + 1) / 2);
  localparam int BankDepth = PhysDepth / 2;
  localparam int PtrW      = $clog2(PhysDepth);
  localparam int AddrW     = $clog2(BankDepth);
  localparam int CntW      = $clog2(RING_DEPTH);
  localparam logic [CntW-1:0] CntMax  = CntW'(RING_DEPTH - 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(PhysDepth - 1);
  localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + PtrOne;
  endfunction

  logic [7:0]      bank0 [BankDepth];
  logic [7:0]      bank1 [BankDepth];
  logic [7:0]      rd0_r, rd1_r;
  logic            sel_r;
  logic [PtrW-1:0] head_r, head_nxt, tail_r, tail_nxt, tail_a;
  logic [CntW-1:0] cnt_r, cnt_nxt, cnt_a;
  logic            ok_a, ok_b;
  logic            we0, we1;
  logic [AddrW-1:0] addr0, addr1, raddr;
  logic [7:0]      data0, data1;

  always_comb begin
    ok_a     = req.push_a && (cnt_r != CntMax);
    cnt_a    = cnt_r + CntW'(ok_a);
    ok_b     = ok_a && req.push_b && (cnt_a != CntMax);
    tail_a   = ptr_inc(tail_r);
    tail_nxt = ok_b ? ptr_inc(tail_a) : (ok_a ? tail_a : tail_r);
    head_nxt = req.fetch ? ptr_inc(head_r) : head_r;
    cnt_nxt  = cnt_a + CntW'(ok_b) - CntW'(req.fetch);
    we0   = (ok_a && !tail_r[0]) || (ok_b && !tail_a[0]);
    we1   = (ok_a && tail_r[0]) || (ok_b && tail_a[0]);
    addr0 = !tail_r[0] ? tail_r[PtrW-1:1] : tail_a[PtrW-1:1];
    addr1 = tail_r[0] ? tail_r[PtrW-1:1] : tail_a[PtrW-1:1];
    data0 = !tail_r[0] ? req.code_a : req.code_b;
    data1 = tail_r[0] ? req.code_a : req.code_b;
    raddr = head_r[PtrW-1:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      sel_r  <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      if (req.fetch) begin
        sel_r <= head_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we0) begin
      bank0[addr0] <= data0;
    end
    if (we1) begin
      bank1[addr1] <= data1;
    end
    if (req.fetch) begin
      rd0_r <= bank0[raddr];
      rd1_r <= bank1[raddr];
    end
  end

  assign empty        = (cnt_r == '0);
  assign fetched_code = sel_r ? rd1_r : rd0_r;

`ifndef ASSERT_OFF
  logic [PtrW-1:0] used_chk;
  assign used_chk = (tail_r >= head_r) ? (tail_r - head_r)
                                       : PtrW'(PhysDepth - int'(head_r) + int'(tail_r));

  a_count_matches_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    used_chk == PtrW'(cnt_r))
    else $error("ring count disagrees with pointers");

  a_full_drops_push: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CntMax && !req.fetch) |=> $stable(tail_r))
    else $error("push accepted into full ring");

  a_no_fetch_empty: assert property (@(posedge clk) disable iff (!rst_n)
    req.fetch |-> !empty)
    else $error("fetch from empty ring");
`endif

endmodule

FILE: verif/kmpi_port_checker.sv
// ----------------------------------------------------------------------------
// kmpi_port_checker: result checker for the keyboard and mouse port block
// Watches both stream channels. Every accepted input word updates a local
// copy of the port state (scan-code ring, latch, control and status bytes,
// mouse counters) and queues the word it must produce. Each accepted output
// word is compared field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module kmpi_port_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,  // port[7:0] wdata[15:8] mouse_dx[23:16] mouse_dy[31:24]
                                 // mouse_buttons[33:32] speaker_out[34] nmi_pending[35]
  input  logic [2:0]  in_tuser,  // cmd[2:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata, // rdata[7:0] kbd_irq[8] system_reset[9]
                                 // timer_gate[10] speaker_drive[11]
  output int unsigned fail_count,
  output int unsigned pending_count
);
  import kmpi_pkg::*;

  typedef struct packed {
    logic       speaker_drive;
    logic       timer_gate;
    logic       system_reset;
    logic       kbd_irq;
    logic [7:0] rdata;
  } port_result_t;

  logic [7:0]   scan_ring [16];
  logic [3:0]   head_ptr;
  logic [3:0]   tail_ptr;
  logic [7:0]   ctrl_byte;
  logic [7:0]   port_a;
  logic [7:0]   bios_stat1;
  logic [7:0]   bios_stat2;
  logic         fetch_armed;
  logic [7:0]   fetched_code;
  logic [7:0]   mouse_x;
  logic [7:0]   mouse_y;
  logic [1:0]   buttons_prev;
  port_result_t port_results_due [$];
  port_result_t due_word;
  port_result_t seen_word;
  int unsigned  mismatch_total = 0;

  assign fail_count = mismatch_total;

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch on %s: got %02h, expected %02h (t=%0t)", field, got, want, $time);
    mismatch_total++;
  endtask

  // drop the code when 15 are already waiting
  task automatic queue_code(input logic [7:0] code);
    if (4'(tail_ptr - head_ptr) != 4'd15) begin
      scan_ring[tail_ptr] = code;
      tail_ptr = tail_ptr + 4'd1;
    end
  endtask

  task automatic fetch_code();
    fetched_code = scan_ring[head_ptr];
    head_ptr = head_ptr + 4'd1;
    fetch_armed = 1'b1;
  endtask

  task automatic predict_port_result(input logic [2:0] cmd, input logic [39:0] word);
    logic [7:0]   port;
    logic [7:0]   wdata;
    logic [7:0]   dx;
    logic [7:0]   dy;
    logic [1:0]   btn;
    logic         spk;
    logic         nmi;
    port_result_t res;
    port  = word[7:0];
    wdata = word[15:8];
    dx    = word[23:16];
    dy    = word[31:24];
    btn   = word[33:32];
    spk   = word[34];
    nmi   = word[35];
    res   = '0;
    res.rdata = RDATA_IDLE;
    case (cmd)
      CMD_WRITE: begin
        case (port)
          PORT_CTRL: begin
            if (!ctrl_byte[6] && wdata[6]) queue_code(CODE_SELFTEST);
            ctrl_byte = wdata;
            if (wdata[7]) port_a = '0;
          end
          PORT_STAT1:  bios_stat1 = wdata;
          PORT_STAT2:  bios_stat2 = wdata;
          PORT_SYSRST: res.system_reset = 1'b1;
          default: ;
        endcase
      end
      CMD_READ: begin
        case (port)
          PORT_DATA: begin
            if (ctrl_byte[7]) begin
              res.rdata = (STAT_SET_MASK | bios_stat1) & STAT_KEEP_MASK;
            end else begin
              res.rdata = port_a;
              if (tail_ptr == head_ptr) fetch_armed = 1'b0;
              else fetch_code();
            end
          end
          PORT_CTRL: res.rdata = ctrl_byte;
          PORT_PORTC: begin
            if (ctrl_byte[2]) res.rdata = bios_stat2 & NIBBLE_MASK;
            else res.rdata = bios_stat2 >> 4;
            res.rdata[5] = spk;
            res.rdata[6] = nmi;
          end
          PORT_MOUSE_X: begin
            res.rdata = mouse_x;
            mouse_x = '0;
          end
          PORT_MOUSE_Y: begin
            res.rdata = mouse_y;
            mouse_y = '0;
          end
          default: ;
        endcase
      end
      CMD_POLL: begin
        if (fetch_armed) begin
          fetch_armed = 1'b0;
          port_a = fetched_code;
          res.kbd_irq = 1'b1;
        end
        if (tail_ptr != head_ptr && port_a == 8'd0) fetch_code();
      end
      CMD_KEY: queue_code(wdata);
      CMD_MOUSE: begin
        mouse_x = mouse_x + dx;
        mouse_y = mouse_y - dy;
        if (btn[0] && !buttons_prev[0]) queue_code(CODE_LEFT_DN);
        if (!btn[0] && buttons_prev[0]) queue_code(CODE_LEFT_UP);
        if (btn[1] && !buttons_prev[1]) queue_code(CODE_RIGHT_DN);
        if (!btn[1] && buttons_prev[1]) queue_code(CODE_RIGHT_UP);
        buttons_prev = btn;
      end
      default: ;
    endcase
    res.timer_gate    = ctrl_byte[0];
    res.speaker_drive = ctrl_byte[1];
    port_results_due.push_back(res);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      head_ptr     = '0;
      tail_ptr     = '0;
      ctrl_byte    = '0;
      port_a       = '0;
      bios_stat1   = '0;
      bios_stat2   = '0;
      fetch_armed  = 1'b0;
      fetched_code = '0;
      mouse_x      = '0;
      mouse_y      = '0;
      buttons_prev = '0;
      port_results_due.delete();
    end else begin
      if (in_tvalid && in_tready) predict_port_result(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        seen_word = out_tdata[11:0];
        if (port_results_due.size() == 0) begin
          report_mismatch("unpredicted word", out_tdata[7:0], RDATA_IDLE);
        end else begin
          due_word = port_results_due.pop_front();
          if (seen_word.rdata != due_word.rdata)
            report_mismatch("rdata", seen_word.rdata, due_word.rdata);
          if (seen_word.kbd_irq != due_word.kbd_irq)
            report_mismatch("kbd_irq", 8'(seen_word.kbd_irq), 8'(due_word.kbd_irq));
          if (seen_word.system_reset != due_word.system_reset)
            report_mismatch("system_reset", 8'(seen_word.system_reset),
                            8'(due_word.system_reset));
          if (seen_word.timer_gate != due_word.timer_gate)
            report_mismatch("timer_gate", 8'(seen_word.timer_gate),
                            8'(due_word.timer_gate));
          if (seen_word.speaker_drive != due_word.speaker_drive)
            report_mismatch("speaker_drive", 8'(seen_word.speaker_drive),
                            8'(due_word.speaker_drive));
        end
      end
    end
    pending_count <= port_results_due.size();
  end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: keyboard and mouse port block
// Drives bus reads and writes, poll ticks, key bytes and mouse reports into
// the block: a directed opening over the special cases, then random service
// sequences, key bursts and noise. Both stream sides idle at random and the
// receiver holds off for long stretches to back the block up. A checker
// beside the block predicts and compares every output word.
// ----------------------------------------------------------------------------
module testbench;
  import kmpi_pkg::*;

  localparam int          RANDOM_WORDS = 1050;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          HOLD_CYCLES  = 120;
  localparam logic [7:0]  PORT_UNUSED  = 8'h63;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // port[7:0] wdata[15:8] mouse_dx[23:16] mouse_dy[31:24]
                           // mouse_buttons[33:32] speaker_out[34] nmi_pending[35]
  logic [2:0]  in_tuser;   // cmd[2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // rdata[7:0] kbd_irq[8] system_reset[9]
                           // timer_gate[10] speaker_drive[11]
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned idle_cycles = 0;
  int unsigned words_offered = 0;
  logic        sender_no_gap = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  keyboard_mouse_port_interface_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  kmpi_port_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** keyboard_mouse_port_interface_top: FAILED **");
      $finish;
    end
  end

  function automatic logic [7:0] pick_port();
    case ($urandom_range(0, 11))
      0, 1:    pick_port = PORT_DATA;
      2, 3:    pick_port = PORT_CTRL;
      4:       pick_port = PORT_PORTC;
      5:       pick_port = PORT_STAT1;
      6:       pick_port = PORT_STAT2;
      7:       pick_port = PORT_SYSRST;
      8:       pick_port = PORT_MOUSE_X;
      9:       pick_port = PORT_MOUSE_Y;
      10:      pick_port = PORT_UNUSED;
      default: pick_port = 8'($urandom);
    endcase
  endfunction

  // hold the word until accepted, return at the following falling edge
  task automatic offer_word(input cmd_t cmd, input logic [7:0] port, input logic [7:0] wdata,
                            input logic [7:0] dx, input logic [7:0] dy,
                            input logic [1:0] btn);
    int unsigned gap;
    if (words_offered % 64 == 0) sender_no_gap = ($urandom_range(0, 3) == 0);
    gap = sender_no_gap ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  <= cmd;
    in_tdata  <= {4'b0, 1'($urandom), 1'($urandom), btn, dy, dx, wdata, port};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    words_offered++;
    @(negedge clk);
  endtask

  initial begin
    int unsigned hold;
    int unsigned taken;
    logic        recv_no_gap;
    out_tready  = 1'b0;
    taken       = 0;
    recv_no_gap = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (taken % 50 == 0) recv_no_gap = ($urandom_range(0, 3) == 0);
      hold = recv_no_gap ? 0 : $urandom_range(0, 6);
      if (taken == 250 || taken == 700) hold = HOLD_CYCLES;
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      taken++;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_WRITE;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    offer_word(CMD_READ,  PORT_DATA,   8'h00, 8'h00, 8'h00, 2'b00);
    offer_word(CMD_WRITE, PORT_CTRL,   8'h40, 8'h00, 8'h00, 2'b00);
    offer_word(CMD_POLL,  PORT_DATA,   8'h00, 8'h00, 8'h00, 2'b00);
    offer_word(CMD_POLL,  PORT_DATA,   8'h00, 8'h00, 8'h00, 2'b00);
    offer_word(CMD_READ,  PORT_DATA,   8'h00, 8'h00, 8'h00, 2'b00);
    offer_word(CMD_WRITE, PORT_STAT1,  8'hFF, 8'h00, 8'h00, 2'b00);
    offer_word(CMD_WRITE, PORT_STAT2,  8'hA5, 8'h00, 8'h00, 2'b00);
    offer_word(CMD_WRITE, PORT_CTRL,   8'h87, 8'h00, 8'h00, 2'b00);
    offer_word(CMD_READ,  PORT_DATA,   8'h00, 8'h00, 8'h00, 2'b00);
    offer_word(CMD_READ,  PORT_PORTC,  8'h00, 8'h00, 8'h00, 2'b00);
    offer_word(CMD_WRITE, PORT_CTRL,   8'h00, 8'h00, 8'h00, 2'b00);
    offer_word(CMD_READ,  PORT_PORTC,  8'hFF, 8'hFF, 8'hFF, 2'b00);
    offer_word(CMD_READ,  PORT_CTRL,   8'h00, 8'h00, 8'h00, 2'b00);
    offer_word(CMD_MOUSE, PORT_DATA,   8'h00, 8'h7F, 8'h80, 2'b11);
    offer_word(CMD_MOUSE, PORT_DATA,   8'h00, 8'h80, 8'h7F, 2'b00);
    offer_word(CMD_READ,  PORT_MOUSE_X, 8'h00, 8'h00, 8'h00, 2'b00);
    offer_word(CMD_READ,  PORT_MOUSE_Y, 8'h00, 8'h00, 8'h00, 2'b00);
    offer_word(CMD_WRITE, PORT_SYSRST, 8'hFF, 8'h00, 8'h00, 2'b00);
    offer_word(CMD_WRITE, PORT_UNUSED, 8'hFF, 8'h00, 8'h00, 2'b00);
    offer_word(CMD_READ,  PORT_UNUSED, 8'h00, 8'h00, 8'h00, 2'b00);
    // fill the ring past its limit: four button codes plus twelve keys
    offer_word(CMD_KEY, PORT_DATA, 8'h00, 8'h00, 8'h00, 2'b00);
    repeat (10) offer_word(CMD_KEY, pick_port(), 8'($urandom), 8'h00, 8'h00, 2'b00);
    offer_word(CMD_KEY, PORT_DATA, 8'hFF, 8'h00, 8'h00, 2'b00);

    words_offered = 0;
    while (words_offered < RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(1, 18))
            offer_word(CMD_KEY, pick_port(), 8'($urandom), 8'($urandom), 8'($urandom),
                       2'($urandom));
        end
        2, 3, 4: begin
          // service one key: tick, read the data port, acknowledge through bit 7
          offer_word(CMD_POLL, pick_port(), 8'($urandom), 8'($urandom), 8'($urandom),
                     2'($urandom));
          offer_word(CMD_READ, PORT_DATA, 8'($urandom), 8'($urandom), 8'($urandom),
                     2'($urandom));
          offer_word(CMD_WRITE, PORT_CTRL, 8'($urandom) | 8'h80, 8'($urandom),
                     8'($urandom), 2'($urandom));
          offer_word(CMD_WRITE, PORT_CTRL, 8'($urandom) & 8'h7F, 8'($urandom),
                     8'($urandom), 2'($urandom));
          if ($urandom_range(0, 1) == 0)
            offer_word(CMD_POLL, pick_port(), 8'($urandom), 8'($urandom), 8'($urandom),
                       2'($urandom));
        end
        5: begin
          repeat ($urandom_range(1, 4))
            offer_word(CMD_MOUSE, pick_port(), 8'($urandom), 8'($urandom), 8'($urandom),
                       2'($urandom));
          offer_word(CMD_READ, ($urandom_range(0, 1) == 0) ? PORT_MOUSE_X : PORT_MOUSE_Y,
                     8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom));
        end
        6: begin
          repeat ($urandom_range(1, 3))
            offer_word(CMD_POLL, pick_port(), 8'($urandom), 8'($urandom), 8'($urandom),
                       2'($urandom));
        end
        default: begin
          offer_word(cmd_t'($urandom_range(0, 4)), pick_port(), 8'($urandom), 8'($urandom),
                     8'($urandom), 2'($urandom));
        end
      endcase
    end
    in_tvalid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("** keyboard_mouse_port_interface_top: PASSED **");
    end else begin
      $display("** keyboard_mouse_port_interface_top: FAILED **");
    end
    $finish;
  end

endmodule
